// File: design/mau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, codes, state encoding and controller/datapath bundles.
// ---------------------------------------------------------------------------
package mau_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int OPERAND_W  = DATA_WIDTH - 1;
   localparam int MOD_W      = 62;
   localparam int ACTION_W   = 2;
   localparam int RED_CNT_W  = $clog2(OPERAND_W + 1);

   localparam logic [MOD_W-1:0]     MODULUS_RESET = MOD_W'(1000000007);
   localparam logic [RED_CNT_W-1:0] RED_STEPS     = RED_CNT_W'(OPERAND_W);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD = 2'd0,
      ACT_MUL = 2'd1,
      ACT_POW = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MP_INIT,
      ST_MP_LOOP,
      ST_POW_CHECK,
      ST_PA_INIT,
      ST_PA_LOOP,
      ST_SQ_INIT,
      ST_SQ_LOOP,
      ST_FINISH
   } state_type;

   // Operand pair loaded into the shift-add multiplier.
   typedef enum logic [1:0] {
      MS_OPERANDS,
      MS_ACC_SQ,
      MS_SQ_SQ
   } mul_src_type;

   // Source of the value written to the result register.
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_SUM,
      RES_MACC,
      RES_PACC
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        red_step;
      logic        mul_init;
      mul_src_type mul_src;
      logic        mul_step;
      logic        wr_pacc;
      logic        wr_sq;
      logic        pow_init;
      logic        expo_shift;
      logic        res_load;
      res_sel_type res_sel;
   } mau_cmd_type;

   typedef struct packed {
      logic       red_done;
      logic       mbits_zero;
      logic       expo_zero;
      logic       expo_lsb;
      logic       mod_small;
      action_type action;
   } mau_status_type;

endpackage
`default_nettype wire

// File: design/mau_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying an action and two operands.
// ---------------------------------------------------------------------------
interface mau_req_if import mau_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [OPERAND_W-1:0] first_operand;
   logic [OPERAND_W-1:0] second_operand;

   modport source (output valid, action, first_operand, second_operand, input ready);
   modport sink   (input valid, action, first_operand, second_operand, output ready);

endinterface
`default_nettype wire

// File: design/mau_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one reduced result.
// ---------------------------------------------------------------------------
interface mau_rsp_if import mau_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [MOD_W-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);

endinterface
`default_nettype wire

// File: design/mau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Modular arithmetic unit controller
// Sequences reduction, shift-add multiplies and square-and-multiply steps.
// ---------------------------------------------------------------------------
module mau_ctrl import mau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  mau_status_type status,
   output mau_cmd_type    cmd
);

   state_type   state_ff, state_in;
   res_sel_type res_sel_ff, res_sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_sel_ff   <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_sel_ff   <= res_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      res_sel_in   = res_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!status.red_done) begin
               cmd.red_step = 1'b1;
            end else if (status.mod_small) begin
               res_sel_in = RES_ZERO;
               state_in   = ST_FINISH;
            end else begin
               case (status.action)
                  ACT_ADD: begin
                     res_sel_in = RES_SUM;
                     state_in   = ST_FINISH;
                  end
                  ACT_MUL: begin
                     state_in = ST_MP_INIT;
                  end
                  ACT_POW: begin
                     cmd.pow_init = 1'b1;
                     state_in     = ST_POW_CHECK;
                  end
                  default: begin
                     res_sel_in = RES_ZERO;
                     state_in   = ST_FINISH;
                  end
               endcase
            end
         end
         ST_MP_INIT: begin
            cmd.mul_init = 1'b1;
            cmd.mul_src  = MS_OPERANDS;
            state_in     = ST_MP_LOOP;
         end
         ST_MP_LOOP: begin
            if (status.mbits_zero) begin
               res_sel_in = RES_MACC;
               state_in   = ST_FINISH;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_POW_CHECK: begin
            if (status.expo_zero) begin
               res_sel_in = RES_PACC;
               state_in   = ST_FINISH;
            end else if (status.expo_lsb) begin
               state_in = ST_PA_INIT;
            end else begin
               state_in = ST_SQ_INIT;
            end
         end
         ST_PA_INIT: begin
            cmd.mul_init = 1'b1;
            cmd.mul_src  = MS_ACC_SQ;
            state_in     = ST_PA_LOOP;
         end
         ST_PA_LOOP: begin
            if (status.mbits_zero) begin
               cmd.wr_pacc = 1'b1;
               state_in    = ST_SQ_INIT;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_SQ_INIT: begin
            cmd.mul_init = 1'b1;
            cmd.mul_src  = MS_SQ_SQ;
            state_in     = ST_SQ_LOOP;
         end
         ST_SQ_LOOP: begin
            if (status.mbits_zero) begin
               cmd.wr_sq      = 1'b1;
               cmd.expo_shift = 1'b1;
               state_in       = ST_POW_CHECK;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_FINISH: begin
            // The result register doubles as the output register, so wait until it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = res_sel_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: design/mau_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Modular arithmetic unit datapath
// Bit-serial remainder, shift-add modular multiplier and power registers.
// ---------------------------------------------------------------------------
module mau_datapath import mau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MOD_W-1:0]     csr_wr_data,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [OPERAND_W-1:0] req_first_operand,
   input  logic [OPERAND_W-1:0] req_second_operand,
   input  mau_cmd_type          cmd,
   output mau_status_type       status,
   output logic [MOD_W-1:0]     rsp_result
);

   logic [MOD_W-1:0]     modulus_ff, modulus_in;
   action_type           action_ff, action_in;
   logic [OPERAND_W-1:0] shift_a_ff, shift_a_in;
   logic [OPERAND_W-1:0] shift_b_ff, shift_b_in;
   logic [MOD_W-1:0]     rem_a_ff, rem_a_in;
   logic [MOD_W-1:0]     rem_b_ff, rem_b_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic [OPERAND_W-1:0] expo_ff, expo_in;
   logic [MOD_W-1:0]     macc_ff, macc_in;
   logic [MOD_W-1:0]     addend_ff, addend_in;
   logic [MOD_W-1:0]     mbits_ff, mbits_in;
   logic [MOD_W-1:0]     pacc_ff, pacc_in;
   logic [MOD_W-1:0]     sq_ff, sq_in;
   logic [MOD_W-1:0]     result_ff, result_in;

   // Sum of two residues, brought back below the modulus with one subtract.
   function automatic logic [MOD_W-1:0] mod_sum(input logic [MOD_W-1:0] x,
                                                input logic [MOD_W-1:0] y,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_W-1:0];
   endfunction

   // One restoring-division step on the partial remainder.
   function automatic logic [MOD_W-1:0] red_reduce(input logic [MOD_W:0]   t,
                                                   input logic [MOD_W-1:0] m);
      logic [MOD_W:0] r;
      r = t;
      if (t >= {1'b0, m}) begin
         r = t - {1'b0, m};
      end
      return r[MOD_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         red_cnt_ff <= '0;
      end else begin
         modulus_ff <= modulus_in;
         red_cnt_ff <= red_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      shift_a_ff <= shift_a_in;
      shift_b_ff <= shift_b_in;
      rem_a_ff   <= rem_a_in;
      rem_b_ff   <= rem_b_in;
      expo_ff    <= expo_in;
      macc_ff    <= macc_in;
      addend_ff  <= addend_in;
      mbits_ff   <= mbits_in;
      pacc_ff    <= pacc_in;
      sq_ff      <= sq_in;
      result_ff  <= result_in;
   end

   always_comb begin
      modulus_in = modulus_ff;
      action_in  = action_ff;
      shift_a_in = shift_a_ff;
      shift_b_in = shift_b_ff;
      rem_a_in   = rem_a_ff;
      rem_b_in   = rem_b_ff;
      red_cnt_in = red_cnt_ff;
      expo_in    = expo_ff;
      macc_in    = macc_ff;
      addend_in  = addend_ff;
      mbits_in   = mbits_ff;
      pacc_in    = pacc_ff;
      sq_in      = sq_ff;
      result_in  = result_ff;

      if (csr_wr_en) begin
         modulus_in = csr_wr_data;
      end

      // Both operands are reduced side by side, one bit per cycle, MSB first.
      if (cmd.load) begin
         action_in  = action_type'(req_action);
         shift_a_in = req_first_operand;
         shift_b_in = req_second_operand;
         rem_a_in   = '0;
         rem_b_in   = '0;
         red_cnt_in = RED_STEPS;
         expo_in    = req_second_operand;
      end else if (cmd.red_step) begin
         rem_a_in   = red_reduce({rem_a_ff, shift_a_ff[OPERAND_W-1]}, modulus_ff);
         rem_b_in   = red_reduce({rem_b_ff, shift_b_ff[OPERAND_W-1]}, modulus_ff);
         shift_a_in = shift_a_ff << 1;
         shift_b_in = shift_b_ff << 1;
         red_cnt_in = red_cnt_ff - RED_CNT_W'(1);
      end

      if (cmd.expo_shift) begin
         expo_in = expo_ff >> 1;
      end

      if (cmd.mul_init) begin
         macc_in = '0;
         case (cmd.mul_src)
            MS_ACC_SQ: begin
               addend_in = pacc_ff;
               mbits_in  = sq_ff;
            end
            MS_SQ_SQ: begin
               addend_in = sq_ff;
               mbits_in  = sq_ff;
            end
            default: begin
               addend_in = rem_a_ff;
               mbits_in  = rem_b_ff;
            end
         endcase
      end else if (cmd.mul_step) begin
         if (mbits_ff[0]) begin
            macc_in = mod_sum(macc_ff, addend_ff, modulus_ff);
         end
         mbits_in  = mbits_ff >> 1;
         addend_in = mod_sum(addend_ff, addend_ff, modulus_ff);
      end

      if (cmd.pow_init) begin
         pacc_in = MOD_W'(1);
         sq_in   = rem_a_ff;
      end
      if (cmd.wr_pacc) begin
         pacc_in = macc_ff;
      end
      if (cmd.wr_sq) begin
         sq_in = macc_ff;
      end

      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_SUM:  result_in = mod_sum(rem_a_ff, rem_b_ff, modulus_ff);
            RES_MACC: result_in = macc_ff;
            RES_PACC: result_in = pacc_ff;
            default:  result_in = '0;
         endcase
      end
   end

   always_comb begin
      status.red_done   = (red_cnt_ff == '0);
      status.mbits_zero = (mbits_ff == '0);
      status.expo_zero  = (expo_ff == '0);
      status.expo_lsb   = expo_ff[0];
      status.mod_small  = (modulus_ff < MOD_W'(2));
      status.action     = action_ff;
   end

   assign rsp_result = result_ff;

endmodule
`default_nettype wire

// File: design/modular_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: add runs a 63-step operand remainder, a decision step and the finish state;
// multiply adds a shift-add loop of up to 62 steps with load and exit states; power runs
// a multiply for each set exponent bit and a square for each bit through the highest one.
// Requests: one at a time; the next is taken the cycle after the result is loaded into
// the output register.
// Reset: synchronous, active high; the modulus returns to 1000000007 and the unit idles.
// ---------------------------------------------------------------------------
// Modular arithmetic unit
// Modular add, multiply and square-and-multiply power with a programmable modulus.
// ---------------------------------------------------------------------------
module modular_arith_unit import mau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mau_req_if.sink          req_chan,
   mau_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [MOD_W-1:0] csr_wr_data
);

   mau_cmd_type    cmd;
   mau_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   logic [MOD_W-1:0] rsp_result;

   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mau_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_action         (req_chan.action),
      .req_first_operand  (req_chan.first_operand),
      .req_second_operand (req_chan.second_operand),
      .cmd                (cmd),
      .status             (status),
      .rsp_result         (rsp_result)
   );

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.result = rsp_result;

endmodule
`default_nettype wire
